/* rtl/core/ssi_mtv_pkg.sv */
`timescale 1ns / 1ps

package ssi_mtv_pkg;

   // Frame layout: the single-turn position sits in the top bits of the frame.
   localparam int FRAME_BITS    = 18;
   localparam int POSITION_BITS = 12;
   localparam int TIME_BITS     = 32;
   localparam int OUT_BITS      = 32;

   // Configuration register widths and reset values.
   localparam int CPR_W    = 13;
   localparam int THR_W    = 12;
   localparam int PERIOD_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CPR_W-1:0]    CPR_RESET = 13'd4096;
   localparam logic [THR_W-1:0]    THR_RESET = 12'd3276;
   localparam logic [PERIOD_W-1:0] MAX_RESET = 32'd500000;
   localparam logic [PERIOD_W-1:0] FB_RESET  = 32'd1000;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_CPR = 2'd0;
   localparam logic [1:0] REG_THR = 2'd1;
   localparam logic [1:0] REG_MAX = 2'd2;
   localparam logic [1:0] REG_FB  = 2'd3;

   // Shared multiplier operands and product.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam logic signed [MUL_B_W-1:0] USEC_PER_SEC = 21'sd1000000;

   // Divider: magnitude of the scaled angle change over the interval.
   localparam int NUM_W  = PROD_W - 1;
   localparam int DEN_W  = PERIOD_W;
   localparam int QCNT_W = $clog2(NUM_W);

   typedef struct packed {
      logic [FRAME_BITS-1:0] ssi_frame;
      logic [TIME_BITS-1:0]  timestamp_us;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] angle_counts;
      logic signed [OUT_BITS-1:0] velocity_cps;
      logic [POSITION_BITS-1:0]   position;
      logic                       turn_overflow;
   } rsp_word_type;

endpackage

/* rtl/core/ssi_mtv_div.sv */
`timescale 1ns / 1ps

module ssi_mtv_div
   import ssi_mtv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;

   logic [DEN_W:0]    rem_sh;
   logic              fits;

   // One restoring step: shift in the next numerator bit and try a subtract.
   assign rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
   assign fits   = (rem_sh >= {1'b0, den});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - {1'b0, den}) : rem_sh;
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == QCNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

/* rtl/core/ssi_encoder_multiturn_velocity.sv */
`timescale 1ns / 1ps
// Each accepted word passes through the turn update, the angle product and clamp, the angle
// change, the velocity product and the 53-step shared divider; the first word after reset
// only primes the stored angle and time. The block works on one word at a time.
// A finished word waits in the output register, so the next word is taken meanwhile.
// Reset (synchronous, active high) restores the register defaults and unprimes the block.

module ssi_encoder_multiturn_velocity
   import ssi_mtv_pkg::*;
#(
   parameter int TURN_BITS = 20
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_TURN   = 4'd1;
   localparam logic [3:0] S_AMUL   = 4'd2;
   localparam logic [3:0] S_ANGLE  = 4'd3;
   localparam logic [3:0] S_DIFF   = 4'd4;
   localparam logic [3:0] S_VMUL   = 4'd5;
   localparam logic [3:0] S_DSTART = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   localparam int D_W   = POSITION_BITS + 1;
   localparam int SUM_W = PROD_W + 1;
   localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(64'sd2147483648);
   localparam logic [NUM_W-1:0] Q_POS_MAX = NUM_W'(64'd2147483647);
   localparam logic [NUM_W-1:0] Q_NEG_MAX = NUM_W'(64'd2147483648);
   localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   // Configuration registers.
   logic [CPR_W-1:0]    cpr_ff;
   logic [THR_W-1:0]    thr_ff;
   logic [PERIOD_W-1:0] max_ff;
   logic [PERIOD_W-1:0] fb_ff;

   // Sequencer and unwrap state.
   logic [3:0]                   state_ff, state_in;
   logic                         primed_ff, primed_in;
   logic signed [TURN_BITS-1:0]  turn_ff, turn_in;
   logic [POSITION_BITS-1:0]     prev_pos_ff, prev_pos_in;
   logic [TIME_BITS-1:0]         prev_time_ff, prev_time_in;
   logic signed [OUT_BITS-1:0]   prev_angle_ff, prev_angle_in;

   // Per-word datapath.
   logic [POSITION_BITS-1:0]     pos_ff, pos_in;
   logic [TIME_BITS-1:0]         now_ff, now_in;
   logic [DEN_W-1:0]             den_ff, den_in;
   logic signed [MUL_A_W-1:0]    op_a_ff, op_a_in;
   logic signed [MUL_B_W-1:0]    op_b_ff, op_b_in;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [OUT_BITS-1:0]   angle_ff, angle_in;
   logic signed [OUT_BITS-1:0]   vel_ff, vel_in;
   logic                         ovf_ff, ovf_in;
   logic                         neg_ff, neg_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_word_ff, rsp_word_in;

   logic                         accept;
   logic                         cfg_write;
   logic signed [D_W-1:0]        pos_delta;
   logic [D_W-1:0]               pos_mag;
   logic                         wrapped;
   logic [TIME_BITS-1:0]         dt_raw;
   logic [PERIOD_W-1:0]          fb_eff;
   logic signed [SUM_W-1:0]      angle_sum;
   logic [NUM_W-1:0]             num_abs;
   logic                         div_start;
   logic                         div_done;
   logic [NUM_W-1:0]             div_quot;

   assign accept    = req_valid && !req_stall;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register file: writes land in the access phase, reads are a plain mux.
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[3:2])
         REG_CPR: csr_prdata = CSR_DATA_W'(cpr_ff);
         REG_THR: csr_prdata = CSR_DATA_W'(thr_ff);
         REG_MAX: csr_prdata = max_ff;
         REG_FB:  csr_prdata = fb_ff;
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff <= CPR_RESET;
         thr_ff <= THR_RESET;
         max_ff <= MAX_RESET;
         fb_ff  <= FB_RESET;
      end else if (cfg_write) begin
         case (csr_paddr[3:2])
            REG_CPR: cpr_ff <= csr_pwdata[CPR_W-1:0];
            REG_THR: thr_ff <= csr_pwdata[THR_W-1:0];
            REG_MAX: max_ff <= csr_pwdata[PERIOD_W-1:0];
            REG_FB:  fb_ff  <= csr_pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // Wrap detection and interval selection.
   assign pos_delta = $signed({1'b0, pos_ff}) - $signed({1'b0, prev_pos_ff});
   assign pos_mag   = pos_delta[D_W-1] ? D_W'(-pos_delta) : D_W'(pos_delta);
   assign wrapped   = (pos_mag > D_W'(thr_ff));
   assign dt_raw    = now_ff - prev_time_ff;
   assign fb_eff    = (fb_ff == '0) ? PERIOD_W'(1) : fb_ff;

   // Angle before clamping: product of the turn count and counts per turn plus position.
   assign angle_sum = SUM_W'(prod_ff) + $signed({{(SUM_W-POSITION_BITS){1'b0}}, pos_ff});

   // Divider operand is the magnitude of the scaled angle change.
   assign num_abs   = prod_ff[PROD_W-1] ? NUM_W'(-prod_ff) : NUM_W'(prod_ff);
   assign div_start = (state_ff == S_DSTART);

   ssi_mtv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_abs),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Sequencer: one word at a time through the shared multiplier and divider.
   always_comb begin
      state_in      = state_ff;
      primed_in     = primed_ff;
      turn_in       = turn_ff;
      prev_pos_in   = prev_pos_ff;
      prev_time_in  = prev_time_ff;
      prev_angle_in = prev_angle_ff;
      pos_in        = pos_ff;
      now_in        = now_ff;
      den_in        = den_ff;
      op_a_in       = op_a_ff;
      op_b_in       = op_b_ff;
      angle_in      = angle_ff;
      vel_in        = vel_ff;
      ovf_in        = ovf_ff;
      neg_in        = neg_ff;
      // The output register empties when its word is taken.
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in   = req_data.ssi_frame[FRAME_BITS-1 -: POSITION_BITS];
               now_in   = req_data.timestamp_us;
               state_in = S_TURN;
            end
         end
         S_TURN: begin
            prev_pos_in  = pos_ff;
            prev_time_in = now_ff;
            ovf_in       = 1'b0;
            if (!primed_ff) begin
               primed_in     = 1'b1;
               turn_in       = '0;
               angle_in      = $signed({{(OUT_BITS-POSITION_BITS){1'b0}}, pos_ff});
               prev_angle_in = $signed({{(OUT_BITS-POSITION_BITS){1'b0}}, pos_ff});
               vel_in        = '0;
               state_in      = S_OUT;
            end else begin
               if (wrapped && !pos_delta[D_W-1]) begin
                  if (turn_ff == TURN_MIN) ovf_in = 1'b1;
                  else turn_in = turn_ff - 1'b1;
               end else if (wrapped) begin
                  if (turn_ff == TURN_MAX) ovf_in = 1'b1;
                  else turn_in = turn_ff + 1'b1;
               end
               op_a_in  = MUL_A_W'(turn_in);
               op_b_in  = $signed({{(MUL_B_W-CPR_W){1'b0}}, cpr_ff});
               den_in   = ((dt_raw == '0) || (dt_raw > max_ff)) ? fb_eff : dt_raw;
               state_in = S_AMUL;
            end
         end
         S_AMUL: begin
            state_in = S_ANGLE;
         end
         S_ANGLE: begin
            if (angle_sum > SUM_HI)      angle_in = OUT_MAX;
            else if (angle_sum < SUM_LO) angle_in = OUT_MIN;
            else                         angle_in = angle_sum[OUT_BITS-1:0];
            state_in = S_DIFF;
         end
         S_DIFF: begin
            op_a_in  = MUL_A_W'(angle_ff) - MUL_A_W'(prev_angle_ff);
            op_b_in  = USEC_PER_SEC;
            state_in = S_VMUL;
         end
         S_VMUL: begin
            state_in = S_DSTART;
         end
         S_DSTART: begin
            neg_in        = prod_ff[PROD_W-1];
            prev_angle_in = angle_ff;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               if (neg_ff) begin
                  vel_in = (div_quot > Q_NEG_MAX) ? OUT_MIN : -$signed(div_quot[OUT_BITS-1:0]);
               end else begin
                  vel_in = (div_quot > Q_POS_MAX) ? OUT_MAX : $signed(div_quot[OUT_BITS-1:0]);
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Hand the word to the output register once it has room.
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{angle_counts:  angle_ff,
                                velocity_cps:  vel_ff,
                                position:      pos_ff,
                                turn_overflow: ovf_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers; the shared multiplier is registered every cycle.
   always_ff @(posedge clock) begin
      turn_ff       <= turn_in;
      prev_pos_ff   <= prev_pos_in;
      prev_time_ff  <= prev_time_in;
      prev_angle_ff <= prev_angle_in;
      pos_ff        <= pos_in;
      now_ff        <= now_in;
      den_ff        <= den_in;
      op_a_ff       <= op_a_in;
      op_b_ff       <= op_b_in;
      prod_ff       <= op_a_ff * op_b_ff;
      angle_ff      <= angle_in;
      vel_ff        <= vel_in;
      ovf_ff        <= ovf_in;
      neg_ff        <= neg_in;
      rsp_word_ff   <= rsp_word_in;
   end

   // Result word.
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

/* rtl/core/ssi_mtv_check.sv */
`timescale 1ns / 1ps

module ssi_mtv_check
   import ssi_mtv_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // A held result word keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result word changed while stalled");

   // A word just taken in cannot publish a new result on the next edge.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after input");

   // The block is busy right after it takes a word.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word taken while the first is in progress");

   // A new result word is published as the input opens again.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("input still closed after a result was published");

endmodule

bind ssi_encoder_multiturn_velocity ssi_mtv_check u_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/ssi_mtv_checker.sv */
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own copy of the
// encoder state and predicts every result word from the accepted input words.
module ssi_mtv_checker
   import ssi_mtv_pkg::*;
#(
   parameter int TURN_BITS = 20
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_word_type          req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_word_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    pending
);

   localparam longint TURN_MAX = (longint'(1) <<< (TURN_BITS - 1)) - 1;
   localparam longint TURN_MIN = -TURN_MAX - 1;
   localparam longint I32_MAX  = 2147483647;
   localparam longint I32_MIN  = -I32_MAX - 1;

   // Register copies.
   logic [CPR_W-1:0]    cpr;
   logic [THR_W-1:0]    wrap_thr;
   logic [PERIOD_W-1:0] max_period;
   logic [PERIOD_W-1:0] fallback;

   // Tracked encoder state.
   logic [POSITION_BITS-1:0] last_pos;
   longint                   turns;
   longint                   last_angle;
   logic [TIME_BITS-1:0]     last_time;
   bit                       primed;

   rsp_word_type motion_q[$];
   int           errors = 0;

   function automatic longint sat32(input longint v);
      if (v > I32_MAX) return I32_MAX;
      if (v < I32_MIN) return I32_MIN;
      return v;
   endfunction

   // Unwraps the position, updates the turn count and derives the velocity.
   function automatic rsp_word_type track_motion(input req_word_type w);
      rsp_word_type             r;
      logic [POSITION_BITS-1:0] pos;
      logic [TIME_BITS-1:0]     dt;
      longint                   jump;
      longint                   angle;
      longint                   vel;
      logic                     ovf;
      pos = w.ssi_frame[FRAME_BITS-1 -: POSITION_BITS];
      vel = 0;
      ovf = 1'b0;
      if (!primed) begin
         // The first word only primes the stored values.
         primed = 1'b1;
         turns  = 0;
         angle  = longint'(pos);
      end else begin
         jump = longint'(pos) - longint'(last_pos);
         if ((jump < 0 ? -jump : jump) > longint'(wrap_thr)) begin
            if (jump > 0) begin
               if (turns <= TURN_MIN) ovf = 1'b1;
               else turns = turns - 1;
            end else begin
               if (turns >= TURN_MAX) ovf = 1'b1;
               else turns = turns + 1;
            end
         end
         angle = sat32(turns * longint'(cpr) + longint'(pos));

         // A zero or overlong interval falls back; a zero fallback counts as one.
         dt = w.timestamp_us - last_time;
         if (dt == '0 || dt > max_period) dt = fallback;
         if (dt == '0) dt = 1;
         vel = sat32(((angle - last_angle) * 1000000) / longint'({32'b0, dt}));
      end
      last_pos   = pos;
      last_time  = w.timestamp_us;
      last_angle = angle;
      r.angle_counts  = angle[OUT_BITS-1:0];
      r.velocity_cps  = vel[OUT_BITS-1:0];
      r.position      = pos;
      r.turn_overflow = ovf;
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Result words are compared before the input word of the same edge is added.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         cpr        = CPR_RESET;
         wrap_thr   = THR_RESET;
         max_period = MAX_RESET;
         fallback   = FB_RESET;
         last_pos   = '0;
         turns      = 0;
         last_angle = 0;
         last_time  = '0;
         primed     = 1'b0;
         motion_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_CPR: cpr        = csr_pwdata[CPR_W-1:0];
               REG_THR: wrap_thr   = csr_pwdata[THR_W-1:0];
               REG_MAX: max_period = csr_pwdata[PERIOD_W-1:0];
               REG_FB:  fallback   = csr_pwdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (motion_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word, expected none, got %h",
                        $time, rsp_data);
            end else begin
               want = motion_q.pop_front();
               check_field("angle_counts", want.angle_counts, rsp_data.angle_counts);
               check_field("velocity_cps", want.velocity_cps, rsp_data.velocity_cps);
               check_field("position", want.position, rsp_data.position);
               check_field("turn_overflow", want.turn_overflow, rsp_data.turn_overflow);
            end
         end
         if (req_valid && !req_stall) motion_q.push_back(track_motion(req_data));
      end
      fail_count <= errors;
      pending    <= motion_q.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
   import ssi_mtv_pkg::*;
;

   localparam int IDLE_LIMIT  = 20000;
   localparam int HOLD_CYCLES = 1500;
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 62;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending;
   int idle_cycles = 0;

   // Shared between the sender and the receiver.
   bit quiet = 1'b0;
   bit hold_pending = 1'b0;

   // Sender's view of the encoder shaft.
   logic [PERIOD_W-1:0]      max_us = MAX_RESET;
   logic [POSITION_BITS-1:0] shaft_pos;
   logic [TIME_BITS-1:0]     clock_us;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ssi_encoder_multiturn_velocity dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ssi_mtv_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // Offers one word after a random gap, or at once when quiet, and holds it until it is taken.
   task automatic send_sample(input logic [FRAME_BITS-1:0] frame,
                              input logic [TIME_BITS-1:0] ts);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{ssi_frame: frame, timestamp_us: ts};
      do @(posedge clock); while (req_stall);
   endtask

   // Setup cycle, then access cycle; the register takes the data at the end of the access cycle.
   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Narrow registers get random upper bits, which the block must drop.
   task automatic apply_setting(input logic [CPR_W-1:0] cpr, input logic [THR_W-1:0] thr,
                                input logic [PERIOD_W-1:0] max_p,
                                input logic [PERIOD_W-1:0] fb);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      junk[CPR_W-1:0] = cpr;
      write_reg(REG_CPR, junk);
      junk = $urandom;
      junk[THR_W-1:0] = thr;
      write_reg(REG_THR, junk);
      write_reg(REG_MAX, max_p);
      write_reg(REG_FB, fb);
      max_us = max_p;
   endtask

   // Stops offering and waits until every predicted word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Receiver: a random stall before each word (none when quiet), or one long hold when asked.
   initial begin
      int n;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            n = HOLD_CYCLES;
         end else if (quiet) begin
            n = 0;
         end else begin
            n = $urandom_range(0, 14);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Watchdog on cycles without any accepted or delivered word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("ssi_encoder_multiturn_velocity regression: fail");
         $finish;
      end
   end

   initial begin
      int                   pick;
      logic [POSITION_BITS-1:0] step;
      logic [TIME_BITS-1:0] dt;
      logic [FRAME_BITS-1:0] frame;
      bit                   spin_up;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset settings. The first one primes.
      send_sample({12'hFFF, 6'h3F}, 32'hFFFF_FFF0);
      // Interval wraps through zero; position rolls over upward.
      send_sample({12'h000, 6'h00}, 32'h0000_0005);
      // Zero interval uses the fallback; position rolls over downward.
      send_sample({12'hFFF, 6'h2A}, 32'h0000_0005);
      // Interval exactly at the maximum, then one above it.
      send_sample({12'h800, 6'h15}, 32'd500005);
      send_sample({12'h801, 6'h00}, 32'd1000006);
      send_sample({12'h000, 6'h3F}, 32'd1000007);
      // Jumps exactly at the threshold with a one microsecond interval saturate velocity.
      send_sample({12'hCCC, 6'h01}, 32'd1000008);
      send_sample({12'h000, 6'h02}, 32'd1000009);
      // One count past the threshold is a wrap in either direction.
      send_sample({12'hCCD, 6'h04}, 32'd1000010);
      send_sample({12'h000, 6'h08}, 32'd1000011);
      // Largest wrapped interval, then a still shaft, then time zero.
      send_sample({12'h000, 6'h10}, 32'd1000010);
      send_sample({12'h000, 6'h20}, 32'd1000011);
      send_sample({12'h7FF, 6'h00}, 32'h0000_0000);
      drain();

      shaft_pos = 12'h7FF;
      clock_us  = 32'hFFFF_F000;

      // Phases of settings, extremes first, then random ones.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_setting(CPR_RESET, THR_RESET, MAX_RESET, FB_RESET);
            1: apply_setting(13'd1, 12'd0, 32'd1, 32'd0);
            2: apply_setting(13'd0, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            3: apply_setting(13'd8191, 12'd1, 32'd2, 32'd1);
            4: apply_setting(13'd4096, 12'd2048, 32'd3000, 32'd1);
            default: apply_setting(CPR_W'($urandom_range(0, 8191)),
                                   THR_W'($urandom_range(0, 4095)),
                                   PERIOD_W'($urandom_range(1, 4000) << $urandom_range(0, 20)),
                                   PERIOD_W'($urandom));
         endcase
         quiet   = (p == 4);
         spin_up = $urandom_range(0, 1);
         if (p == 5 || p == 8) hold_pending = 1'b1;

         for (int i = 0; i < PHASE_WORDS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               // A turning shaft: mostly small steps one way, now and then big ones.
               step = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                                  : 12'($urandom_range(0, 200));
               if (spin_up ^ ($urandom_range(0, 4) == 0)) shaft_pos = shaft_pos + step;
               else shaft_pos = shaft_pos - step;
               pick = $urandom_range(0, 99);
               if (pick < 80) dt = $urandom_range(1, 3000);
               else if (pick < 85) dt = '0;
               else if (pick < 90) dt = max_us;
               else if (pick < 95) dt = max_us + 1;
               else dt = $urandom;
               clock_us = clock_us + dt;
               frame = {shaft_pos, 6'($urandom)};
            end else begin
               // Noise: any frame at any time.
               frame     = FRAME_BITS'($urandom);
               clock_us  = $urandom;
               shaft_pos = frame[FRAME_BITS-1 -: POSITION_BITS];
            end
            send_sample(frame, clock_us);
         end
         drain();
      end

      quiet = 1'b0;
      repeat (80) @(posedge clock);
      if (fail_count == 0) begin
         $display("ssi_encoder_multiturn_velocity regression: pass");
      end else begin
         $display("ssi_encoder_multiturn_velocity regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/ssi_mtv_pkg.sv
rtl/core/ssi_mtv_div.sv
rtl/core/ssi_encoder_multiturn_velocity.sv
rtl/core/ssi_mtv_check.sv
tb/ssi_mtv_checker.sv
tb/tb_top.sv
